/* rtl/eamb_pkg.sv */
// Package for the Euler affine matrix builder: widths, CORDIC gain and arctangent table.
// No dependencies.
`default_nettype none
package eamb_pkg;
  localparam int CordicStepsDef = 16;
  localparam int TableLen = 24;
  localparam logic signed [33:0] GainQ30 = 34'sd652032874;

  function automatic logic signed [33:0] atan_phase(input int i);
    logic signed [33:0] r;
    case (i)
      0: r = 34'sh20000000;  1: r = 34'sh12E4051E;  2: r = 34'sh09FB385B;
      3: r = 34'sh051111D4;  4: r = 34'sh028B0D43;  5: r = 34'sh0145D7E1;
      6: r = 34'sh00A2F61E;  7: r = 34'sh00517C55;  8: r = 34'sh0028BE53;
      9: r = 34'sh00145F2F; 10: r = 34'sh000A2F98; 11: r = 34'sh000517CC;
      12: r = 34'sh00028BE6; 13: r = 34'sh000145F3; 14: r = 34'sh0000A2FA;
      15: r = 34'sh0000517D; 16: r = 34'sh000028BE; 17: r = 34'sh0000145F;
      18: r = 34'sh00000A30; 19: r = 34'sh00000518; 20: r = 34'sh0000028C;
      21: r = 34'sh00000146; 22: r = 34'sh000000A3; 23: r = 34'sh00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
  } vec_t;

  typedef struct packed {
    logic signed [17:0] ca;
    logic signed [17:0] sa;
    logic signed [17:0] cb;
    logic signed [17:0] sb;
  } trig_t;
endpackage
`default_nettype wire

/* rtl/eamb_cordic.sv */
// Pipelined CORDIC: one stage per iteration, stall-aware, sine and cosine in signed Q1.16.
// Depends on eamb_pkg.
`default_nettype none
module eamb_cordic import eamb_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [15:0]        angle,
  output logic signed [17:0]      cos_o,
  output logic signed [17:0]      sin_o
);
  localparam int N = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;

  logic signed [33:0] x_r [0:N];
  logic signed [33:0] y_r [0:N];
  logic signed [33:0] z_r [0:N];
  logic [1:0]         q_r [0:N];
  logic [31:0]        p;
  logic [1:0]         q;

  assign p = {angle, 16'd0};
  assign q = 2'((p + 32'h20000000) >> 30);

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GainQ30;
      y_r[0] <= '0;
      z_r[0] <= 34'(signed'(p - {q, 30'd0}));
      q_r[0] <= q;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1] <= q_r[i];
        if (!z_r[i][33]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_phase(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_phase(i);
        end
      end
    end
  end

  logic signed [33:0] xs, ys;
  logic signed [17:0] xc, yc;
  assign xs = (x_r[N] + 34'sd8192) >>> 14;
  assign ys = (y_r[N] + 34'sd8192) >>> 14;
  assign xc = (xs > 34'sd65536) ? 18'sd65536 : (xs < -34'sd65536) ? -18'sd65536 : 18'(xs);
  assign yc = (ys > 34'sd65536) ? 18'sd65536 : (ys < -34'sd65536) ? -18'sd65536 : 18'(ys);

  always_ff @(posedge clk) begin
    if (en) begin
      case (q_r[N])
        2'd0: begin cos_o <= xc;  sin_o <= yc;  end
        2'd1: begin cos_o <= -yc; sin_o <= xc;  end
        2'd2: begin cos_o <= -xc; sin_o <= -yc; end
        default: begin cos_o <= yc; sin_o <= -xc; end
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/eamb_matrix.sv */
// Matrix stages: rotation products, then translation products, then row sums and saturation.
// Depends on eamb_pkg.
`default_nettype none
module eamb_matrix import eamb_pkg::*; (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire trig_t        trig,
  input  wire vec_t         t,
  output logic [383:0]      mat
);
  logic signed [17:0] r_r [0:8];
  vec_t               t1_r;
  logic signed [49:0] p_r [0:8];
  logic signed [17:0] r2_r [0:8];
  logic signed [35:0] m_sasb, m_sacb, m_casb, m_cacb;

  assign m_sasb = trig.sa * trig.sb;
  assign m_sacb = trig.sa * trig.cb;
  assign m_casb = trig.ca * trig.sb;
  assign m_cacb = trig.ca * trig.cb;

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0] <= trig.cb;
      r_r[1] <= '0;
      r_r[2] <= trig.sb;
      r_r[3] <= -18'((m_sasb + 36'sd32768) >>> 16);
      r_r[4] <= trig.ca;
      r_r[5] <= 18'((m_sacb + 36'sd32768) >>> 16);
      r_r[6] <= -18'((m_casb + 36'sd32768) >>> 16);
      r_r[7] <= -trig.sa;
      r_r[8] <= 18'((m_cacb + 36'sd32768) >>> 16);
      t1_r   <= t;
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_p
    logic signed [31:0] tv;
    assign tv = (k % 3 == 0) ? t1_r.tx : (k % 3 == 1) ? t1_r.ty : t1_r.tz;
    always_ff @(posedge clk) begin
      if (en) begin
        p_r[k]  <= 50'(r_r[k]) * 50'(tv);
        r2_r[k] <= r_r[k];
      end
    end
  end

  for (genvar rr = 0; rr < 3; rr++) begin : g_row
    logic signed [51:0] acc, sh;
    logic signed [31:0] sat;
    assign acc = 52'(p_r[3*rr]) + 52'(p_r[3*rr+1]) + 52'(p_r[3*rr+2]) + 52'sd32768;
    assign sh  = acc >>> 16;
    assign sat = (sh > 52'sd2147483647) ? 32'sh7FFFFFFF :
                 (sh < -52'sd2147483648) ? 32'sh80000000 : 32'(sh);
    always_ff @(posedge clk) begin
      if (en) begin
        mat[128*rr +: 32]      <= 32'(r2_r[3*rr]);
        mat[128*rr + 32 +: 32] <= 32'(r2_r[3*rr+1]);
        mat[128*rr + 64 +: 32] <= 32'(r2_r[3*rr+2]);
        mat[128*rr + 96 +: 32] <= sat;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/euler_affine_matrix_builder_top.sv */
// Throughput: one item per cycle; the whole pipeline advances when the output stage
// is free or taken, so back-to-back transfers run at full rate.
// Reset: synchronous active-low rst_n clears all stage valid bits; data is not reset.
// Depends on eamb_pkg, eamb_cordic, eamb_matrix.
`default_nettype none
module euler_affine_matrix_builder_top import eamb_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // angle_a, angle_b, trans_x, trans_y, trans_z
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [383:0]      out_tdata   // e00 e01 e02 e03 e10 ... e23
);
  localparam int N = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;
  localparam int LAT = N + 5;
  localparam int VDEL = N + 2;

  logic en;
  logic [LAT-1:0] v_r;
  vec_t t_r [0:VDEL-1];
  trig_t trig;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign out_tvalid = v_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0] <= '{tx: in_tdata[63:32], ty: in_tdata[95:64], tz: in_tdata[127:96]};
      for (int i = 1; i < VDEL; i++) t_r[i] <= t_r[i-1];
    end
  end

  eamb_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_ca (
    .clk(clk), .en(en), .angle(in_tdata[15:0]), .cos_o(trig.ca), .sin_o(trig.sa));
  eamb_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cb (
    .clk(clk), .en(en), .angle(in_tdata[31:16]), .cos_o(trig.cb), .sin_o(trig.sb));

  eamb_matrix u_mat (
    .clk(clk), .en(en), .trig(trig), .t(t_r[VDEL-1]), .mat(out_tdata));
endmodule
`default_nettype wire

/* rtl/eamb_checker.sv */
// Port-level checker for the matrix builder, bound to the top level.
// Depends on euler_affine_matrix_builder_top ports only.
`default_nettype none
module eamb_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [383:0] out_tdata
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("ready");
  a_e01: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[63:32] == 32'd0) else $error("e01");
  a_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[31:0]) <= 32'sd65536 &&
                    $signed(out_tdata[31:0]) >= -32'sd65536)) else $error("range");
endmodule
bind euler_affine_matrix_builder_top eamb_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata));
`default_nettype wire
